// ===== rtl/rppf_pkg.sv =====
package rppf_pkg;

    // codec packet lengths above this are clipped
    localparam int MAX_PACKET = 8191;

    localparam int LEN_W   = 13;
    localparam int TYPE_W  = 2;
    localparam int TS_W    = 32;
    localparam int SEQ_W   = 16;
    localparam int IDENT_W = 24;
    localparam int KIND_W  = 2;
    localparam int COUNT_W = 4;
    localparam int BYTES_W = 11;
    localparam int INDEX_W = 16;

    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 120;
    localparam int OUT_USER_W = 4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [BYTES_W-1:0] LIMIT_LO    = 11'd256;
    localparam logic [BYTES_W-1:0] LIMIT_HI    = 11'd1400;
    localparam logic [BYTES_W-1:0] LIMIT_RESET = 11'd1000;
    localparam logic [COUNT_W-1:0] STACK_RESET = 4'd15;
    localparam logic [BYTES_W-1:0] PREFIX_BYTES = 11'd2;

    localparam logic [TYPE_W-1:0] TYPE_RAW = 2'd0;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PAYLOAD_LIMIT   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STACK_LIMIT     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONFIG_IDENT    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_SEQUENCE  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_TIMESTAMP = 3'd4;

    typedef enum logic [KIND_W-1:0] {
        KIND_WHOLE  = 2'd0,
        KIND_FIRST  = 2'd1,
        KIND_MIDDLE = 2'd2,
        KIND_LAST   = 2'd3
    } frag_kind_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_PLAN,
        OP_FLUSH,
        OP_PUSH,
        OP_WHOLE,
        OP_FRAG
    } dp_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLAN,
        ST_FLUSH_PRE,
        ST_PUSH,
        ST_FLUSH_END,
        ST_WHOLE,
        ST_FRAG
    } ctrl_state_t;

    typedef struct packed {
        logic flush_pre;
        logic push;
        logic flush_end;
        logic whole;
        logic frag;
    } plan_t;

    typedef struct packed {
        dp_op_t op;
        logic   last;
    } dp_cmd_t;

    typedef struct packed {
        plan_t plan;
        logic  frag_more;
        logic  out_free;
    } dp_stat_t;

endpackage

// ===== rtl/rtp_payload_pack_fragment_planner.sv =====
// channel   dir  tdata (low bit first)                             tuser                   tlast
// s_        in   pkt_length[12:0] ts_increment[44:13] pad[47:45]   pkt_type[1:0]           end_flag
// m_        out  seq_number[15:0] rtp_timestamp[47:16]             frag_kind[1:0]          last_of_run
//                ident_out[71:48] packet_count[75:72]              type_out[3:2]
//                payload_bytes[86:76] source_index[102:87]
//                source_offset[115:103] pad[119:116]
// cfg       in   cfg_wr_en, cfg_index[2:0], cfg_data[31:0]
//
// each accepted word is loaded and planned; the sequencer then walks flush, push,
// end flush, single send and fragment steps and emits at most one word per cycle.
// a stalled m_ side holds the sequencer at its next emitting step; s_tready is low
// while a word is in work. aresetn is synchronous; registers that have a reset value take it.
module rtp_payload_pack_fragment_planner
    import rppf_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_DATA_W-1:0]   s_tdata,   // pkt_length, ts_increment
    input  logic [IN_USER_W-1:0]   s_tuser,   // pkt_type
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,   // seq_number, rtp_timestamp, ident_out,
                                              // packet_count, payload_bytes, source_index,
                                              // source_offset
    output logic [OUT_USER_W-1:0]  m_tuser,   // frag_kind, type_out
    output logic                   m_tlast,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    rppf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rppf_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_len    (s_tdata[LEN_W-1:0]),
        .in_type   (s_tuser),
        .in_inc    (s_tdata[LEN_W+TS_W-1:LEN_W]),
        .in_end    (s_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== rtl/rppf_ctrl.sv =====
module rppf_ctrl
    import rppf_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;
    plan_t       plan_reg, plan_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            plan_reg  <= '0;
        end else begin
            state_reg <= state_next;
            plan_reg  <= plan_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        plan_next  = plan_reg;
        cmd.op     = OP_NONE;
        cmd.last   = 1'b0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_PLAN;
                end
            end
            ST_PLAN: begin
                // flags are taken from the stack as it stood before this word
                cmd.op     = OP_PLAN;
                plan_next  = stat.plan;
                state_next = ST_FLUSH_PRE;
            end
            ST_FLUSH_PRE: begin
                if (!plan_reg.flush_pre) begin
                    state_next = ST_PUSH;
                end else if (stat.out_free) begin
                    cmd.op     = OP_FLUSH;
                    cmd.last   = !plan_reg.flush_end && !plan_reg.whole && !plan_reg.frag;
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (plan_reg.push) begin
                    cmd.op = OP_PUSH;
                end
                state_next = ST_FLUSH_END;
            end
            ST_FLUSH_END: begin
                if (!plan_reg.flush_end) begin
                    state_next = ST_WHOLE;
                end else if (stat.out_free) begin
                    cmd.op     = OP_FLUSH;
                    cmd.last   = 1'b1;
                    state_next = ST_WHOLE;
                end
            end
            ST_WHOLE: begin
                if (!plan_reg.whole) begin
                    state_next = ST_FRAG;
                end else if (stat.out_free) begin
                    cmd.op     = OP_WHOLE;
                    cmd.last   = 1'b1;
                    state_next = ST_FRAG;
                end
            end
            ST_FRAG: begin
                if (!plan_reg.frag) begin
                    state_next = ST_IDLE;
                end else if (stat.out_free) begin
                    cmd.op   = OP_FRAG;
                    cmd.last = !stat.frag_more;
                    if (!stat.frag_more) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/rppf_dp.sv =====
module rppf_dp
    import rppf_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  dp_cmd_t                cmd,
    output dp_stat_t               stat,
    input  logic [LEN_W-1:0]       in_len,
    input  logic [TYPE_W-1:0]      in_type,
    input  logic [TS_W-1:0]        in_inc,
    input  logic                   in_end,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,
    output logic [OUT_USER_W-1:0]  m_tuser,
    output logic                   m_tlast
);

    // configuration
    logic [BYTES_W-1:0] payload_limit_reg;
    logic [COUNT_W-1:0] stack_limit_reg;
    logic [IDENT_W-1:0] ident_reg;

    // running state
    logic [SEQ_W-1:0]   seq_reg;
    logic [TS_W-1:0]    ts_reg;
    logic [BYTES_W-1:0] stack_bytes_reg;
    logic [COUNT_W-1:0] stack_count_reg;
    logic [INDEX_W-1:0] stack_first_reg;
    logic [INDEX_W-1:0] input_count_reg;

    // current word
    logic [LEN_W-1:0]   len_reg;
    logic [TYPE_W-1:0]  type_reg;
    logic [TS_W-1:0]    inc_reg;
    logic               end_reg;
    logic [INDEX_W-1:0] idx_reg;
    logic [LEN_W-1:0]   rest_reg;
    logic [LEN_W-1:0]   pos_reg;

    // output register
    logic               out_valid_reg;
    logic [SEQ_W-1:0]   out_seq_reg;
    logic [TS_W-1:0]    out_ts_reg;
    logic [IDENT_W-1:0] out_ident_reg;
    frag_kind_t         out_kind_reg;
    logic [TYPE_W-1:0]  out_type_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic [BYTES_W-1:0] out_bytes_reg;
    logic [INDEX_W-1:0] out_idx_reg;
    logic [LEN_W-1:0]   out_off_reg;
    logic               out_last_reg;

    logic [BYTES_W-1:0] lim;
    logic [LEN_W-1:0]   lim_wide;
    logic [LEN_W:0]     stack_sum;
    logic               len_fits;
    logic               stack_fits;
    logic               raw_path;
    logic [LEN_W-1:0]   len_sat;

    logic               emit;
    frag_kind_t         e_kind;
    logic [TYPE_W-1:0]  e_type;
    logic [COUNT_W-1:0] e_count;
    logic [BYTES_W-1:0] e_bytes;
    logic [INDEX_W-1:0] e_idx;
    logic [LEN_W-1:0]   e_off;
    logic               e_step_ts;

    always_comb begin
        if (payload_limit_reg < LIMIT_LO) begin
            lim = LIMIT_LO;
        end else if (payload_limit_reg > LIMIT_HI) begin
            lim = LIMIT_HI;
        end else begin
            lim = payload_limit_reg;
        end
    end

    assign lim_wide   = LEN_W'(lim);
    assign stack_sum  = {1'b0, len_reg} + (LEN_W + 1)'(stack_bytes_reg);
    assign len_fits   = len_reg <= lim_wide;
    assign stack_fits = (stack_sum <= (LEN_W + 1)'(lim)) && (stack_count_reg < stack_limit_reg);
    assign raw_path   = (type_reg == TYPE_RAW) && (len_fits || stack_bytes_reg != '0);
    assign len_sat    = (in_len > LEN_W'(MAX_PACKET)) ? LEN_W'(MAX_PACKET) : in_len;

    always_comb begin
        stat.plan.flush_pre = (stack_count_reg != '0) &&
                              ((type_reg != TYPE_RAW) || (raw_path && !stack_fits));
        stat.plan.push      = (type_reg == TYPE_RAW) && len_fits;
        stat.plan.flush_end = (type_reg == TYPE_RAW) && len_fits && end_reg;
        stat.plan.whole     = (type_reg != TYPE_RAW) && len_fits;
        stat.plan.frag      = !len_fits;
        stat.frag_more      = rest_reg > lim_wide;
        stat.out_free       = !out_valid_reg || m_tready;
    end

    always_comb begin
        emit      = 1'b0;
        e_kind    = KIND_WHOLE;
        e_type    = type_reg;
        e_count   = '0;
        e_bytes   = '0;
        e_idx     = idx_reg;
        e_off     = '0;
        e_step_ts = 1'b0;
        case (cmd.op)
            OP_FLUSH: begin
                emit      = 1'b1;
                e_type    = TYPE_RAW;
                e_count   = stack_count_reg;
                e_bytes   = stack_bytes_reg;
                e_idx     = stack_first_reg;
                e_step_ts = 1'b1;
            end
            OP_WHOLE: begin
                emit      = 1'b1;
                e_count   = COUNT_W'(1);
                e_bytes   = BYTES_W'(len_reg) + PREFIX_BYTES;
                e_step_ts = 1'b1;
            end
            OP_FRAG: begin
                emit  = 1'b1;
                e_off = pos_reg;
                if (stat.frag_more) begin
                    e_kind  = (pos_reg == '0) ? KIND_FIRST : KIND_MIDDLE;
                    e_bytes = lim + PREFIX_BYTES;
                end else begin
                    // last piece carries the timestamp step
                    e_kind    = KIND_LAST;
                    e_bytes   = BYTES_W'(rest_reg) + PREFIX_BYTES;
                    e_step_ts = 1'b1;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            payload_limit_reg <= LIMIT_RESET;
            stack_limit_reg   <= STACK_RESET;
            ident_reg         <= '0;
            seq_reg           <= '0;
            ts_reg            <= '0;
            stack_bytes_reg   <= '0;
            stack_count_reg   <= '0;
            stack_first_reg   <= '0;
            input_count_reg   <= '0;
            out_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_PAYLOAD_LIMIT:   payload_limit_reg <= cfg_data[BYTES_W-1:0];
                    CFG_STACK_LIMIT:     stack_limit_reg   <= cfg_data[COUNT_W-1:0];
                    CFG_CONFIG_IDENT:    ident_reg         <= cfg_data[IDENT_W-1:0];
                    CFG_START_SEQUENCE:  seq_reg           <= cfg_data[SEQ_W-1:0];
                    CFG_START_TIMESTAMP: ts_reg            <= cfg_data[TS_W-1:0];
                    default: ;
                endcase
            end

            if (!emit && m_tready) begin
                out_valid_reg <= 1'b0;
            end

            if (emit) begin
                out_valid_reg <= 1'b1;
                out_seq_reg   <= seq_reg;
                out_ts_reg    <= ts_reg;
                out_ident_reg <= ident_reg;
                out_kind_reg  <= e_kind;
                out_type_reg  <= e_type;
                out_count_reg <= e_count;
                out_bytes_reg <= e_bytes;
                out_idx_reg   <= e_idx;
                out_off_reg   <= e_off;
                out_last_reg  <= cmd.last;
                seq_reg       <= seq_reg + SEQ_W'(1);
                if (e_step_ts) begin
                    ts_reg <= ts_reg + inc_reg;
                end
            end

            case (cmd.op)
                OP_LOAD: begin
                    len_reg         <= len_sat;
                    type_reg        <= in_type;
                    inc_reg         <= in_inc;
                    end_reg         <= in_end;
                    idx_reg         <= input_count_reg;
                    input_count_reg <= input_count_reg + INDEX_W'(1);
                end
                OP_PLAN: begin
                    rest_reg <= len_reg;
                    pos_reg  <= '0;
                end
                OP_FLUSH: begin
                    stack_bytes_reg <= '0;
                    stack_count_reg <= '0;
                end
                OP_PUSH: begin
                    if (stack_count_reg == '0) begin
                        stack_first_reg <= idx_reg;
                    end
                    stack_bytes_reg <= stack_bytes_reg + BYTES_W'(len_reg) + PREFIX_BYTES;
                    stack_count_reg <= stack_count_reg + COUNT_W'(1);
                end
                OP_FRAG: begin
                    rest_reg <= rest_reg - lim_wide;
                    pos_reg  <= pos_reg + lim_wide;
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_off_reg, out_idx_reg, out_bytes_reg, out_count_reg,
                       out_ident_reg, out_ts_reg, out_seq_reg};
    assign m_tuser  = {out_type_reg, out_kind_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ===== rtl/rppf_check.sv =====
module rppf_check
    import rppf_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [OUT_USER_W-1:0] m_tuser,
    input logic                  m_tlast
);

    // a held word keeps its contents
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled output word changed");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // one word in work at a time
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a word is in work");

    // fragments carry no packet count, whole packets at least one
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tuser[KIND_W-1:0] == KIND_WHOLE) == (m_tdata[75:72] != '0)))
        else $error("packet count does not match fragment kind");

    a_first_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[KIND_W-1:0] == KIND_FIRST || m_tuser[KIND_W-1:0] == KIND_MIDDLE)
        |-> !m_tlast)
        else $error("run ends on a leading fragment");

endmodule

bind rtp_payload_pack_fragment_planner rppf_check u_rppf_check (.*);
